FILE: sv/pwga_pkg.sv
`default_nettype none
package pwga_pkg;

    localparam int PIXELS_PER_TILE   = 32;
    localparam int PIX_IDX_W         = $clog2(PIXELS_PER_TILE);
    localparam int DST_W             = 21;
    localparam int CHAN_W            = 16;
    localparam int ADDR_W            = 32;
    localparam int TAP_CNT_W         = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int WINDOW_ROWS_DEF   = 3;
    localparam int WINDOW_COLS_DEF   = 3;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [CHAN_W-1:0] CHANNELS_RST = 16'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNELS     = 3'd0,
        REG_ROW_START    = 3'd1,
        REG_COL_START    = 3'd2,
        REG_ROW_STEP     = 3'd3,
        REG_COL_STEP     = 3'd4,
        REG_TAP_ROW_STEP = 3'd5,
        REG_TAP_COL_STEP = 3'd6,
        REG_COL_LIMIT    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] valid_mask;
        logic [ADDR_W-1:0] image_base;
        logic              new_image;
    } t_in_req;

    typedef struct packed {
        logic              is_pad;
        logic [ADDR_W-1:0] src_offset;
        logic [DST_W-1:0]  dst_offset;
        logic              last;
    } t_out_req;

    typedef struct packed {
        logic [CHAN_W-1:0] channels;
        logic [ADDR_W-1:0] row_start;
        logic [ADDR_W-1:0] col_start;
        logic [ADDR_W-1:0] row_step;
        logic [ADDR_W-1:0] col_step;
        logic [ADDR_W-1:0] tap_row_step;
        logic [ADDR_W-1:0] tap_col_step;
        logic [ADDR_W-1:0] col_limit;
    } t_cfg;

    typedef struct packed {
        logic [PIXELS_PER_TILE-1:0] valid_mask;
        logic [ADDR_W-1:0]          image_base;
        logic [ADDR_W-1:0]          tap_sum;
        logic [ADDR_W-1:0]          row_base;
        logic [ADDR_W-1:0]          col_base;
        logic                       last_tap;
    } t_job;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
    } t_wb;

endpackage
`default_nettype wire

FILE: sv/pool_window_gather_address_gen_unit.sv
// The first address of a request passes through the queue, the back end's job registers and its output register.
// The address stepper gives one address per cycle while the output is not stalled, 32 per request.
// After the last window tap of a tile, the next request waits until the stepper
// returns the final row and column terms as the next tile base.
// Reset is synchronous and active low; it clears the queue, the tap state and the
// tile bases and loads the register defaults (channels 32, all others zero).
`default_nettype none
module pool_window_gather_address_gen_unit #(
    parameter int WINDOW_ROWS = pwga_pkg::WINDOW_ROWS_DEF,
    parameter int WINDOW_COLS = pwga_pkg::WINDOW_COLS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [pwga_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [pwga_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  pwga_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output pwga_pkg::t_out_req                 o_out_req
);

    pwga_pkg::t_cfg r_cfg;
    pwga_pkg::t_job front_job, queue_job;
    pwga_pkg::t_wb  wb;
    logic           q_push, q_pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channels     <= pwga_pkg::CHANNELS_RST;
            r_cfg.row_start    <= '0;
            r_cfg.col_start    <= '0;
            r_cfg.row_step     <= '0;
            r_cfg.col_step     <= '0;
            r_cfg.tap_row_step <= '0;
            r_cfg.tap_col_step <= '0;
            r_cfg.col_limit    <= '0;
        end else if (i_cfg_we) begin
            case (pwga_pkg::t_reg_idx'(i_cfg_idx))
                pwga_pkg::REG_CHANNELS: begin
                    r_cfg.channels <= i_cfg_data[pwga_pkg::CHAN_W-1:0];
                end
                pwga_pkg::REG_ROW_START:    r_cfg.row_start    <= i_cfg_data;
                pwga_pkg::REG_COL_START:    r_cfg.col_start    <= i_cfg_data;
                pwga_pkg::REG_ROW_STEP:     r_cfg.row_step     <= i_cfg_data;
                pwga_pkg::REG_COL_STEP:     r_cfg.col_step     <= i_cfg_data;
                pwga_pkg::REG_TAP_ROW_STEP: r_cfg.tap_row_step <= i_cfg_data;
                pwga_pkg::REG_TAP_COL_STEP: r_cfg.tap_col_step <= i_cfg_data;
                pwga_pkg::REG_COL_LIMIT:    r_cfg.col_limit    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pwga_front #(
        .WINDOW_ROWS (WINDOW_ROWS),
        .WINDOW_COLS (WINDOW_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (front_job),
        .i_wb       (wb)
    );

    pwga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (queue_job),
        .o_empty (q_empty)
    );

    pwga_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_job     (queue_job),
        .o_q_pop     (q_pop),
        .o_wb        (wb),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule
`default_nettype wire

FILE: sv/pwga_front.sv
`default_nettype none
module pwga_front #(
    parameter int WINDOW_ROWS = pwga_pkg::WINDOW_ROWS_DEF,
    parameter int WINDOW_COLS = pwga_pkg::WINDOW_COLS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pwga_pkg::t_cfg     i_cfg,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  pwga_pkg::t_in_req  i_in_req,
    input  wire                i_q_full,
    output logic               o_q_push,
    output pwga_pkg::t_job     o_q_job,
    input  pwga_pkg::t_wb      i_wb
);

    logic [pwga_pkg::ADDR_W-1:0]    r_row_base, n_row_base;
    logic [pwga_pkg::ADDR_W-1:0]    r_col_base, n_col_base;
    logic [pwga_pkg::TAP_CNT_W-1:0] r_row_cnt, n_row_cnt;
    logic [pwga_pkg::TAP_CNT_W-1:0] r_col_cnt, n_col_cnt;
    logic [pwga_pkg::ADDR_W-1:0]    r_row_off, n_row_off;
    logic [pwga_pkg::ADDR_W-1:0]    r_col_off, n_col_off;
    logic                           r_pending;

    logic [pwga_pkg::ADDR_W-1:0]    eff_row_base, eff_col_base, eff_row_off, eff_col_off;
    logic [pwga_pkg::TAP_CNT_W-1:0] eff_row_cnt, eff_col_cnt, col_cnt_inc, row_cnt_inc;
    logic                           col_wrap, row_wrap, accept;

    assign o_in_ready = !r_pending && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = accept;

    always_comb begin
        eff_row_base = i_in_req.new_image ? i_cfg.row_start : r_row_base;
        eff_col_base = i_in_req.new_image ? i_cfg.col_start : r_col_base;
        eff_row_cnt  = i_in_req.new_image ? '0 : r_row_cnt;
        eff_col_cnt  = i_in_req.new_image ? '0 : r_col_cnt;
        eff_row_off  = i_in_req.new_image ? '0 : r_row_off;
        eff_col_off  = i_in_req.new_image ? '0 : r_col_off;

        col_cnt_inc = eff_col_cnt + 1'b1;
        row_cnt_inc = eff_row_cnt + 1'b1;
        col_wrap    = col_cnt_inc >= pwga_pkg::TAP_CNT_W'(WINDOW_COLS);
        row_wrap    = col_wrap && (row_cnt_inc >= pwga_pkg::TAP_CNT_W'(WINDOW_ROWS));

        n_row_base = eff_row_base;
        n_col_base = eff_col_base;
        if (col_wrap) begin
            n_col_cnt = '0;
            n_col_off = '0;
            if (row_wrap) begin
                n_row_cnt = '0;
                n_row_off = '0;
            end else begin
                n_row_cnt = row_cnt_inc;
                n_row_off = eff_row_off + i_cfg.tap_row_step;
            end
        end else begin
            n_col_cnt = col_cnt_inc;
            n_col_off = eff_col_off + i_cfg.tap_col_step;
            n_row_cnt = eff_row_cnt;
            n_row_off = eff_row_off;
        end

        o_q_job.valid_mask = i_in_req.valid_mask;
        o_q_job.image_base = i_in_req.image_base;
        o_q_job.tap_sum    = eff_row_off + eff_col_off;
        o_q_job.row_base   = eff_row_base;
        o_q_job.col_base   = eff_col_base;
        o_q_job.last_tap   = row_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_base <= '0;
            r_col_base <= '0;
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
            r_row_off  <= '0;
            r_col_off  <= '0;
            r_pending  <= 1'b0;
        end else if (i_wb.valid) begin
            r_row_base <= i_wb.row;
            r_col_base <= i_wb.col;
            r_pending  <= 1'b0;
        end else if (accept) begin
            r_row_base <= n_row_base;
            r_col_base <= n_col_base;
            r_row_cnt  <= n_row_cnt;
            r_col_cnt  <= n_col_cnt;
            r_row_off  <= n_row_off;
            r_col_off  <= n_col_off;
            r_pending  <= row_wrap;
        end
    end

endmodule
`default_nettype wire

FILE: sv/pwga_queue.sv
`default_nettype none
module pwga_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  pwga_pkg::t_job  i_job,
    output logic            o_full,
    input  wire             i_pop,
    output pwga_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int PTR_W = (pwga_pkg::QUEUE_DEPTH > 1) ? $clog2(pwga_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pwga_pkg::QUEUE_DEPTH + 1);

    pwga_pkg::t_job    r_mem [pwga_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = r_count == CNT_W'(pwga_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(pwga_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(pwga_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/pwga_back.sv
`default_nettype none
module pwga_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pwga_pkg::t_cfg       i_cfg,
    input  wire                  i_q_empty,
    input  pwga_pkg::t_job       i_q_job,
    output logic                 o_q_pop,
    output pwga_pkg::t_wb        o_wb,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pwga_pkg::t_out_req   o_out_req
);

    logic                                r_active;
    logic [pwga_pkg::PIX_IDX_W-1:0]      r_idx;
    logic [pwga_pkg::PIXELS_PER_TILE-1:0] r_mask;
    logic [pwga_pkg::ADDR_W-1:0]         r_add;
    logic [pwga_pkg::ADDR_W-1:0]         r_row, n_row;
    logic [pwga_pkg::ADDR_W-1:0]         r_col, n_col;
    logic [pwga_pkg::DST_W-1:0]          r_dst;
    logic                                r_last_tap;
    logic                                r_out_valid;
    pwga_pkg::t_out_req                  r_out, n_out;
    logic                                r_wb_valid;
    logic [pwga_pkg::ADDR_W-1:0]         r_wb_row, r_wb_col;

    logic [pwga_pkg::ADDR_W-1:0]         col_sum;
    logic                                step, last_pix, load, real_pix;

    assign step     = r_active && (!r_out_valid || i_out_ready);
    assign last_pix = r_idx == pwga_pkg::PIX_IDX_W'(pwga_pkg::PIXELS_PER_TILE - 1);
    assign load     = !i_q_empty && (!r_active || (step && last_pix));
    assign o_q_pop  = load;
    assign real_pix = r_mask[r_idx];

    always_comb begin
        col_sum = r_col + i_cfg.col_step;
        if (col_sum >= i_cfg.col_limit) begin
            n_col = i_cfg.col_start;
            n_row = r_row + i_cfg.row_step;
        end else begin
            n_col = col_sum;
            n_row = r_row;
        end
        n_out.is_pad     = !real_pix;
        n_out.src_offset = real_pix ? (r_add + r_row + r_col) : '0;
        n_out.dst_offset = r_dst;
        n_out.last       = last_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
            end else if (step && last_pix) begin
                r_active <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_wb_valid <= step && last_pix && r_last_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out    <= n_out;
            r_wb_row <= n_row;
            r_wb_col <= n_col;
        end
        if (load) begin
            r_idx      <= '0;
            r_mask     <= i_q_job.valid_mask;
            r_add      <= i_q_job.image_base + i_q_job.tap_sum;
            r_row      <= i_q_job.row_base;
            r_col      <= i_q_job.col_base;
            r_dst      <= '0;
            r_last_tap <= i_q_job.last_tap;
        end else if (step) begin
            r_idx <= r_idx + 1'b1;
            r_row <= n_row;
            r_col <= n_col;
            r_dst <= r_dst + pwga_pkg::DST_W'(i_cfg.channels);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_wb.valid  = r_wb_valid;
    assign o_wb.row    = r_wb_row;
    assign o_wb.col    = r_wb_col;

endmodule
`default_nettype wire

FILE: bench/pool_window_gather_address_gen_unit_tb.sv
`timescale 1ns / 100ps

import pwga_pkg::*;

class gather_address_predictor;
    t_cfg              regs;
    logic [ADDR_W-1:0] tile_row_base;
    logic [ADDR_W-1:0] tile_col_base;
    logic [ADDR_W-1:0] tap_row_offset;
    logic [ADDR_W-1:0] tap_col_offset;
    logic [3:0]        tap_row_count;
    logic [3:0]        tap_col_count;
    t_out_req          expected_addrs[$];
    int                errors;

    function new();
        regs           = '0;
        regs.channels  = CHANNELS_RST;
        tile_row_base  = '0;
        tile_col_base  = '0;
        tap_row_offset = '0;
        tap_col_offset = '0;
        tap_row_count  = '0;
        tap_col_count  = '0;
        errors         = 0;
    endfunction

    function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CHANNELS:     regs.channels     = data[CHAN_W-1:0];
            REG_ROW_START:    regs.row_start    = data;
            REG_COL_START:    regs.col_start    = data;
            REG_ROW_STEP:     regs.row_step     = data;
            REG_COL_STEP:     regs.col_step     = data;
            REG_TAP_ROW_STEP: regs.tap_row_step = data;
            REG_TAP_COL_STEP: regs.tap_col_step = data;
            REG_COL_LIMIT:    regs.col_limit    = data;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_addrs.size();
    endfunction

    // Expands one mask request into the addresses of its 32 pixels.
    function void add_request(t_in_req req);
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic [ADDR_W-1:0] dst;
        t_out_req          e;
        if (req.new_image) begin
            tile_row_base  = regs.row_start;
            tile_col_base  = regs.col_start;
            tap_row_count  = '0;
            tap_col_count  = '0;
            tap_row_offset = '0;
            tap_col_offset = '0;
        end
        row = tile_row_base;
        col = tile_col_base;
        dst = '0;
        for (int i = 0; i < PIXELS_PER_TILE; i++) begin
            e.is_pad     = !req.valid_mask[i];
            e.src_offset = req.valid_mask[i] ?
                           req.image_base + row + col + tap_row_offset + tap_col_offset : '0;
            e.dst_offset = dst[DST_W-1:0];
            e.last       = (i == PIXELS_PER_TILE - 1);
            expected_addrs.push_back(e);
            col = col + regs.col_step;
            if (col >= regs.col_limit) begin
                col = regs.col_start;
                row = row + regs.row_step;
            end
            dst = dst + ADDR_W'(regs.channels);
        end
        tap_col_count  = tap_col_count + 4'd1;
        tap_col_offset = tap_col_offset + regs.tap_col_step;
        if (tap_col_count >= WINDOW_COLS_DEF) begin
            tap_col_count  = '0;
            tap_col_offset = '0;
            tap_row_count  = tap_row_count + 4'd1;
            tap_row_offset = tap_row_offset + regs.tap_row_step;
            if (tap_row_count >= WINDOW_ROWS_DEF) begin
                tap_row_count  = '0;
                tap_row_offset = '0;
                tile_row_base  = row;
                tile_col_base  = col;
            end
        end
    endfunction

    function void check_address(t_out_req got);
        t_out_req e;
        if (expected_addrs.size() == 0) begin
            $error("address produced with no request pending");
            errors++;
            return;
        end
        e = expected_addrs.pop_front();
        if (got.is_pad !== e.is_pad) begin
            $error("is_pad: expected %0d, got %0d", e.is_pad, got.is_pad);
            errors++;
        end
        if (got.src_offset !== e.src_offset) begin
            $error("src_offset: expected %h, got %h", e.src_offset, got.src_offset);
            errors++;
        end
        if (got.dst_offset !== e.dst_offset) begin
            $error("dst_offset: expected %h, got %h", e.dst_offset, got.dst_offset);
            errors++;
        end
        if (got.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last);
            errors++;
        end
    endfunction
endclass

module pool_window_gather_address_gen_unit_tb;

    localparam int LIMIT         = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 21;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_req               i_in_req;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_req              o_out_req;

    gather_address_predictor bank = new();
    bit                      quiet;
    int                      cycles;

    pool_window_gather_address_gen_unit #(
        .WINDOW_ROWS(WINDOW_ROWS_DEF),
        .WINDOW_COLS(WINDOW_COLS_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 64);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bank.check_address(o_out_req);
        end
    end

    task automatic send_request(logic [31:0] mask, logic [31:0] image_base, logic new_image);
        int      gap;
        t_in_req req;
        req.valid_mask = mask;
        req.image_base = image_base;
        req.new_image  = new_image;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req   = req;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        bank.add_request(req);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (bank.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        bank.write_reg(idx, data);
    endtask

    task automatic write_config(t_cfg c);
        write_reg(REG_CHANNELS, CFG_DATA_W'(c.channels));
        write_reg(REG_ROW_START, c.row_start);
        write_reg(REG_COL_START, c.col_start);
        write_reg(REG_ROW_STEP, c.row_step);
        write_reg(REG_COL_STEP, c.col_step);
        write_reg(REG_TAP_ROW_STEP, c.tap_row_step);
        write_reg(REG_TAP_COL_STEP, c.tap_col_step);
        write_reg(REG_COL_LIMIT, c.col_limit);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_cfg phase_config(int phase);
        t_cfg c;
        c.channels     = $urandom_range(0, 1) ? CHAN_W'($urandom) : CHAN_W'($urandom_range(1, 64));
        c.row_start    = rand_word();
        c.col_start    = rand_word();
        c.row_step     = rand_word();
        c.col_step     = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(0, 8);
        c.tap_row_step = rand_word();
        c.tap_col_step = rand_word();
        c.col_limit    = $urandom_range(0, 3) == 0 ? rand_word() :
                         c.col_start + $urandom_range(0, 64);
        case (phase)
            0: begin
                c          = '1;
            end
            1: begin
                c.channels  = '0;
                c.col_limit = '0;
            end
            2: begin
                c.channels  = 16'd1;
                c.col_limit = c.col_start - $urandom_range(0, 1);
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        t_cfg c;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        quiet      = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(32'hFFFF_FFFF, 32'h0000_0100, 1'b0);
        send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        drain();

        c.channels     = 16'd3;
        c.row_start    = 32'h0000_1000;
        c.col_start    = 32'h0000_0010;
        c.row_step     = 32'h0000_0100;
        c.col_step     = 32'd2;
        c.tap_row_step = 32'h0004_0000;
        c.tap_col_step = 32'h0000_0008;
        c.col_limit    = 32'h0000_0020;
        write_config(c);
        send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        for (int k = 0; k < 9; k++) begin
            send_request(rand_mask(), 32'h0000_4000, 1'b0);
        end
        send_request(32'h8000_0001, 32'h0000_0010, 1'b0);
        send_request(32'hAAAA_AAAA, 32'h0000_0020, 1'b1);
        send_request(32'h7FFF_FFFE, 32'h0000_0030, 1'b0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            quiet = (phase % 3 == 1);
            write_config(phase_config(phase));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_request(rand_mask(),
                             $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096),
                             (k == 0 && $urandom_range(0, 3) != 0) ||
                             $urandom_range(0, 11) == 0);
            end
            drain();
        end

        if (bank.errors == 0 && bank.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/pwga_pkg.sv
sv/pwga_front.sv
sv/pwga_queue.sv
sv/pwga_back.sv
sv/pool_window_gather_address_gen_unit.sv
bench/pool_window_gather_address_gen_unit_tb.sv
